### src/bsbd_pkg.sv
package bsbd_pkg;

    // Default spline degree and fixed sizes of the datapath.
    localparam int DEGREE_DEF = 3;
    localparam int NKNOT      = 8;
    localparam int NLANE      = 18;
    localparam int NSTEP      = 31;

    // Divider lane layout: first full level, level below the top, top level.
    localparam int LANE_A = 0;
    localparam int LANE_B = 6;
    localparam int OFS_GL = 0;
    localparam int OFS_GR = 1;
    localparam int OFS_FL = 2;
    localparam int OFS_FR = 3;
    localparam int C_FL   = 14;
    localparam int C_FR   = 15;
    localparam int C_GL   = 16;
    localparam int C_GR   = 17;

    localparam logic signed [31:0] QONE     = 32'sd65536;
    localparam logic [31:0]        SYM_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0]        SYM_NEG  = 32'h8000_0001;
    localparam logic [47:0]        OUT_NLIM = 48'h0000_8000_0000;

    typedef struct packed {
        logic signed [32:0] num;
        logic signed [32:0] den;
    } frac_t;

    typedef struct packed {
        logic [32:0]       m;
        logic [32:0]       rem;
        logic [NSTEP-1:0]  lo;
        logic [NSTEP-1:0]  q;
        logic              neg;
        logic              ovf;
        logic              zero;
    } div_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               flag;
    } res_t;

    typedef struct packed {
        logic [3:0] init;
        logic       kill;
    } tag_t;

    // Lanes whose quotients take part for a given degree.
    function automatic logic [NLANE-1:0] lane_mask(input int d);
        logic [NLANE-1:0] m;
        m = '0;
        if (d >= 1)
        begin
            m[C_GR:C_FL] = '1;
        end
        if (d >= 2)
        begin
            m[C_FL-1:LANE_B] = '1;
        end
        if (d == 3)
        begin
            m[LANE_B-1:LANE_A] = '1;
        end
        return m;
    endfunction

    // Magnitudes, rounding offset and the upper part of the scaled numerator.
    function automatic div_t div_prep(input frac_t f);
        logic [32:0] an;
        logic [32:0] ad;
        logic [48:0] np;
        div_t        o;
        an     = f.num[32] ? 33'(-f.num) : 33'(f.num);
        ad     = f.den[32] ? 33'(-f.den) : 33'(f.den);
        np     = {an, 16'd0} + 49'(ad >> 1);
        o.m    = ad;
        o.rem  = 33'(np[48:31]);
        o.lo   = np[30:0];
        o.q    = '0;
        o.neg  = f.num[32] ^ f.den[32];
        o.ovf  = 1'b0;
        o.zero = (f.den == '0);
        return o;
    endfunction

    // The quotient overflows 31 bits when the upper part already reaches the divisor.
    function automatic div_t div_check(input div_t d);
        div_t o;
        o     = d;
        o.ovf = (d.rem >= d.m);
        return o;
    endfunction

    // One restoring division step, one quotient bit.
    function automatic div_t div_step(input div_t d);
        logic [32:0] t;
        logic        ge;
        div_t        o;
        o     = d;
        t     = {d.rem[31:0], d.lo[NSTEP-1]};
        ge    = (t >= d.m);
        o.rem = ge ? (t - d.m) : t;
        o.lo  = {d.lo[NSTEP-2:0], 1'b0};
        o.q   = {d.q[NSTEP-2:0], ge};
        return o;
    endfunction

    // Apply sign, clipping and the zero-divisor rule.
    function automatic res_t ratio_fin(input div_t d);
        res_t o;
        o.flag = 1'b0;
        if (d.zero)
        begin
            o.val = '0;
        end
        else if (d.ovf)
        begin
            o.flag = 1'b1;
            o.val  = d.neg ? SYM_NEG : SYM_MAX;
        end
        else
        begin
            o.val = d.neg ? 32'(32'd0 - 32'(d.q)) : 32'(d.q);
        end
        return o;
    endfunction

    function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    // Round Q32.32 to Q16.16, half away from zero, then clip.
    // With full set the negative limit is -2^31, otherwise -(2^31-1).
    function automatic res_t rnd_clip(input logic signed [63:0] s, input logic full);
        logic [63:0] mag;
        logic [47:0] r;
        res_t        o;
        mag    = s[63] ? 64'(-s) : 64'(s);
        r      = 48'((mag + 64'd32768) >> 16);
        o.flag = 1'b0;
        o.val  = 32'(r);
        if (!s[63])
        begin
            if (r > 48'(SYM_MAX))
            begin
                o.flag = 1'b1;
                o.val  = SYM_MAX;
            end
        end
        else if (full)
        begin
            if (r > OUT_NLIM)
            begin
                o.flag = 1'b1;
                o.val  = 32'(OUT_NLIM);
            end
            else
            begin
                o.val = 32'(48'd0 - r);
            end
        end
        else
        begin
            if (r > 48'(SYM_MAX))
            begin
                o.flag = 1'b1;
                o.val  = SYM_NEG;
            end
            else
            begin
                o.val = 32'(48'd0 - r);
            end
        end
        return o;
    endfunction

endpackage

### src/bspline_basis_and_derivs_unit.sv
// Channel   | Signals                                         | Transaction when
// ----------+-------------------------------------------------+--------------------------
// input     | in_valid, in_stall, point, basis_index          | in_valid and not in_stall
// output    | out_valid, out_stall, basis_value,               | out_valid and not out_stall
//           | first_derivative, second_derivative, saturated  |
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data       | cfg_valid and cfg_ready
//
// One point enters every cycle while in_stall is low; the pipeline has 41 register stages,
// and stalled cycles delay each result further.
// The depth is set by the 31-step bit-serial dividers, one stage per quotient bit,
// followed by two stages (multiply, then round and clip) for each recursion level.
// Reset clears all stage valid bits and loads the knots with 0, 1, ... 7.
// A held result freezes the whole pipeline, and in_stall is raised while it is held.
module bspline_basis_and_derivs_unit
    import bsbd_pkg::*;
#(
    parameter int DEGREE = DEGREE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] point,
    input  logic [1:0]         basis_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] basis_value,
    output logic signed [31:0] first_derivative,
    output logic signed [31:0] second_derivative,
    output logic               saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int NDIV  = NSTEP + 2;
    localparam int S_RAT = NDIV + 1;
    localparam int S_PC  = S_RAT + 5;
    localparam int NST   = S_RAT + 7;

    localparam logic [NLANE-1:0] MASK = lane_mask(DEGREE);
    localparam bit USE_A = (DEGREE == 3);
    localparam bit USE_B = (DEGREE >= 2);

    localparam logic [2:0] OB1 = 3'(DEGREE - 1);
    localparam logic [2:0] OB2 = 3'(DEGREE);
    localparam logic [2:0] OC2 = 3'(DEGREE + 1);
    localparam logic signed [32:0] GB_NUM = 33'((DEGREE - 1) * 65536);
    localparam logic signed [32:0] GC_NUM = 33'(DEGREE * 65536);

    logic signed [31:0] knot_reg [NKNOT];
    logic signed [32:0] kw [NKNOT];

    logic [NST-1:0] v_reg;
    tag_t           tag_reg [NST];
    tag_t           tag_next;
    logic           en;

    frac_t frac_next [NLANE];
    frac_t frac_reg  [NLANE];
    div_t  div_reg   [NDIV][NLANE];
    res_t  rat_reg   [NLANE];

    logic signed [31:0] ratv35_reg [NLANE];
    logic signed [31:0] ratv36_reg [NLANE];
    logic signed [31:0] ratv37_reg [NLANE];
    logic signed [31:0] ratv38_reg [NLANE];

    logic signed [63:0] pa_next [6];
    logic signed [63:0] pa_reg  [6];
    logic signed [31:0] binit_reg [3];
    logic signed [31:0] b0 [4];
    res_t               res_a [3];
    logic signed [31:0] ba_next [3];
    logic signed [31:0] ba_reg  [3];
    logic signed [63:0] pb_next [8];
    logic signed [63:0] pb_reg  [8];
    logic signed [31:0] ba37_reg [2];
    res_t               res_p [2];
    res_t               res_b [2];
    logic signed [31:0] bb_next [2];
    logic signed [31:0] bb_reg  [2];
    logic signed [31:0] pd_next [2];
    logic signed [31:0] pd_reg  [2];
    logic signed [63:0] pc_next [6];
    logic signed [63:0] pc_reg  [6];
    res_t               res_v;
    res_t               res_d1;
    res_t               res_d2;

    logic [NLANE-1:0] rflags;
    logic flag35_next, flag35_reg;
    logic flag36_next, flag36_reg;
    logic flag37_reg;
    logic flag38_next, flag38_reg;
    logic flag39_reg;

    logic signed [31:0] bv_next, d1_next, d2_next;
    logic               sat_next;
    logic signed [31:0] bv_reg, d1_reg, d2_reg;
    logic               sat_reg;

    // Handshake: the pipeline moves unless a finished result is being held.
    assign in_stall  = v_reg[NST-1] & out_stall;
    assign en        = ~in_stall;
    assign cfg_ready = 1'b1;

    // Knot registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NKNOT; k++)
            begin
                knot_reg[k] <= 32'(k * 65536);
            end
        end
        else if (cfg_valid)
        begin
            knot_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NKNOT; k++)
        begin
            kw[k] = 33'(knot_reg[k]);
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // Numerators and denominators of every factor the recursion needs.
    always_comb
    begin
        logic [2:0]         l3;
        logic [2:0]         ia;
        logic signed [32:0] xs;
        logic signed [32:0] da;
        logic signed [32:0] db;
        l3 = {1'b0, basis_index};
        xs = 33'(point);
        for (int rr = 0; rr < 3; rr++)
        begin
            ia = l3 + 3'(rr);
            frac_next[LANE_A + 2*rr].num     = xs - kw[ia];
            frac_next[LANE_A + 2*rr].den     = kw[ia + 3'd1] - kw[ia];
            frac_next[LANE_A + 2*rr + 1].num = kw[ia + 3'd2] - xs;
            frac_next[LANE_A + 2*rr + 1].den = kw[ia + 3'd2] - kw[ia + 3'd1];
        end
        for (int rr = 0; rr < 2; rr++)
        begin
            ia = l3 + 3'(rr);
            da = kw[ia + OB1] - kw[ia];
            db = kw[ia + OB2] - kw[ia + 3'd1];
            frac_next[LANE_B + 4*rr + OFS_GL].num = GB_NUM;
            frac_next[LANE_B + 4*rr + OFS_GL].den = da;
            frac_next[LANE_B + 4*rr + OFS_GR].num = GB_NUM;
            frac_next[LANE_B + 4*rr + OFS_GR].den = db;
            frac_next[LANE_B + 4*rr + OFS_FL].num = xs - kw[ia];
            frac_next[LANE_B + 4*rr + OFS_FL].den = da;
            frac_next[LANE_B + 4*rr + OFS_FR].num = kw[ia + OB2] - xs;
            frac_next[LANE_B + 4*rr + OFS_FR].den = db;
        end
        da = kw[l3 + OB2] - kw[l3];
        db = kw[l3 + OC2] - kw[l3 + 3'd1];
        frac_next[C_FL].num = xs - kw[l3];
        frac_next[C_FL].den = da;
        frac_next[C_FR].num = kw[l3 + OC2] - xs;
        frac_next[C_FR].den = db;
        frac_next[C_GL].num = GC_NUM;
        frac_next[C_GL].den = da;
        frac_next[C_GR].num = GC_NUM;
        frac_next[C_GR].den = db;
        tag_next.kill = ({1'b0, basis_index} > 3'(DEGREE));
        tag_next.init = 4'b0001 << (2'(DEGREE) - basis_index);
    end

    // Recursion levels: products, then rounding and clipping.
    always_comb
    begin
        logic fa;
        fa = 1'b0;
        for (int n = 0; n < NLANE; n++)
        begin
            rflags[n] = rat_reg[n].flag;
        end
        flag35_next = |(rflags & MASK);
        for (int k = 0; k < 4; k++)
        begin
            b0[k] = tag_reg[S_RAT].init[k] ? QONE : 32'sd0;
        end
        for (int rr = 0; rr < 3; rr++)
        begin
            pa_next[2*rr]     = mul32(rat_reg[LANE_A + 2*rr].val, b0[rr]);
            pa_next[2*rr + 1] = mul32(rat_reg[LANE_A + 2*rr + 1].val, b0[rr + 1]);
            res_a[rr]         = rnd_clip(pa_reg[2*rr] + pa_reg[2*rr + 1], 1'b0);
            ba_next[rr]       = USE_A ? res_a[rr].val : binit_reg[rr];
            fa                = fa | res_a[rr].flag;
        end
        flag36_next = flag35_reg | (USE_A & fa);

        fa = 1'b0;
        for (int rr = 0; rr < 2; rr++)
        begin
            pb_next[4*rr + 0] = mul32(ratv36_reg[LANE_B + 4*rr + OFS_GL], ba_reg[rr]);
            pb_next[4*rr + 1] = mul32(ratv36_reg[LANE_B + 4*rr + OFS_GR], ba_reg[rr + 1]);
            pb_next[4*rr + 2] = mul32(ratv36_reg[LANE_B + 4*rr + OFS_FL], ba_reg[rr]);
            pb_next[4*rr + 3] = mul32(ratv36_reg[LANE_B + 4*rr + OFS_FR], ba_reg[rr + 1]);
            res_p[rr]   = rnd_clip(pb_reg[4*rr + 0] - pb_reg[4*rr + 1], 1'b0);
            res_b[rr]   = rnd_clip(pb_reg[4*rr + 2] + pb_reg[4*rr + 3], 1'b0);
            pd_next[rr] = USE_B ? res_p[rr].val : 32'sd0;
            bb_next[rr] = USE_B ? res_b[rr].val : ba37_reg[rr];
            fa          = fa | res_p[rr].flag | res_b[rr].flag;
        end
        flag38_next = flag37_reg | (USE_B & fa);

        pc_next[0] = mul32(ratv38_reg[C_FL], bb_reg[0]);
        pc_next[1] = mul32(ratv38_reg[C_FR], bb_reg[1]);
        pc_next[2] = mul32(ratv38_reg[C_GL], bb_reg[0]);
        pc_next[3] = mul32(ratv38_reg[C_GR], bb_reg[1]);
        pc_next[4] = mul32(ratv38_reg[C_GL], pd_reg[0]);
        pc_next[5] = mul32(ratv38_reg[C_GR], pd_reg[1]);

        res_v  = rnd_clip(pc_reg[0] + pc_reg[1], 1'b1);
        res_d1 = rnd_clip(pc_reg[2] - pc_reg[3], 1'b1);
        res_d2 = rnd_clip(pc_reg[4] - pc_reg[5], 1'b1);
        if (tag_reg[S_PC].kill)
        begin
            bv_next  = '0;
            d1_next  = '0;
            d2_next  = '0;
            sat_next = 1'b0;
        end
        else if (DEGREE == 0)
        begin
            bv_next  = QONE;
            d1_next  = '0;
            d2_next  = '0;
            sat_next = 1'b0;
        end
        else
        begin
            bv_next  = res_v.val;
            d1_next  = res_d1.val;
            d2_next  = res_d2.val;
            sat_next = flag39_reg | res_v.flag | res_d1.flag | res_d2.flag;
        end
    end

    // Datapath registers, all advancing together.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag_next;
            for (int s = 1; s < NST; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
            for (int n = 0; n < NLANE; n++)
            begin
                frac_reg[n]   <= frac_next[n];
                div_reg[0][n] <= div_prep(frac_reg[n]);
                div_reg[1][n] <= div_check(div_reg[0][n]);
                for (int s = 2; s < NDIV; s++)
                begin
                    div_reg[s][n] <= div_step(div_reg[s-1][n]);
                end
                rat_reg[n]    <= ratio_fin(div_reg[NDIV-1][n]);
                ratv35_reg[n] <= rat_reg[n].val;
                ratv36_reg[n] <= ratv35_reg[n];
                ratv37_reg[n] <= ratv36_reg[n];
                ratv38_reg[n] <= ratv37_reg[n];
            end
            for (int k = 0; k < 6; k++)
            begin
                pa_reg[k] <= pa_next[k];
                pc_reg[k] <= pc_next[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                binit_reg[k] <= b0[k];
                ba_reg[k]    <= ba_next[k];
            end
            for (int k = 0; k < 8; k++)
            begin
                pb_reg[k] <= pb_next[k];
            end
            for (int k = 0; k < 2; k++)
            begin
                ba37_reg[k] <= ba_reg[k];
                bb_reg[k]   <= bb_next[k];
                pd_reg[k]   <= pd_next[k];
            end
            flag35_reg <= flag35_next;
            flag36_reg <= flag36_next;
            flag37_reg <= flag36_reg;
            flag38_reg <= flag38_next;
            flag39_reg <= flag38_reg;
            bv_reg     <= bv_next;
            d1_reg     <= d1_next;
            d2_reg     <= d2_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid         = v_reg[NST-1];
    assign basis_value       = bv_reg;
    assign first_derivative  = d1_reg;
    assign second_derivative = d2_reg;
    assign saturated         = sat_reg;

endmodule

### src/bsbd_chk.sv
module bsbd_chk
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] basis_value,
    input logic signed [31:0] first_derivative,
    input logic signed [31:0] second_derivative,
    input logic               saturated
);

    // A held result stays presented and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(basis_value)
            && $stable(first_derivative) && $stable(second_derivative)
            && $stable(saturated))
        else $error("held result changed or vanished");

    // The input side only stalls because a result is being held.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // Nothing emerges straight after reset is released.
    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid && (in_valid || !in_valid))
        else $error("result presented straight after reset");

endmodule

bind bspline_basis_and_derivs_unit bsbd_chk u_bsbd_chk (.*);

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsbd_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int DRAIN_CYCLES  = 60;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int RANDOM_ITEMS  = 338;
    localparam int MAX_REPORTS   = 10;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] deriv1;
        logic signed [31:0] deriv2;
        logic               sat;
    } basis_res_t;

    typedef struct {
        logic signed [31:0] pt;
        logic [1:0]         idx;
    } basis_req_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] point;
    logic [1:0]         basis_index;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] basis_value;
    logic signed [31:0] first_derivative;
    logic signed [31:0] second_derivative;
    logic               saturated;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Knot vector as the block should currently hold it.
    logic signed [31:0] knot_copy [NKNOT];
    basis_res_t         pending_results [$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    bit                 stim_done;

    bspline_basis_and_derivs_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .point             (point),
        .basis_index       (basis_index),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .basis_value       (basis_value),
        .first_derivative  (first_derivative),
        .second_derivative (second_derivative),
        .saturated         (saturated),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Fixed-point helpers of the basis evaluation.
    function automatic longint knot_val(int k);
        return longint'(knot_copy[k & (NKNOT - 1)]);
    endfunction

    function automatic longint clip_symmetric(longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483647)
        begin
            flag = 1'b1;
            return -64'sd2147483647;
        end
        return v;
    endfunction

    function automatic longint clip_result(longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Rounded Q16.16 quotient; a zero divisor gives a zero factor.
    function automatic longint knot_ratio(longint num, longint den, inout bit flag);
        bit              neg;
        longint unsigned n;
        longint unsigned m;
        longint unsigned q;
        if (den == 0)
        begin
            return 0;
        end
        neg = (num < 0) != (den < 0);
        n   = longint'(num < 0 ? -num : num) << 16;
        m   = longint'(den < 0 ? -den : den);
        q   = (n + (m >> 1)) / m;
        if (q > 64'd2147483647)
        begin
            flag = 1'b1;
            q    = 64'd2147483647;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint mul_add_round(longint a, longint b, longint c, longint d);
        longint          s;
        longint unsigned mag;
        longint          r;
        s   = a * b + c * d;
        mag = s < 0 ? -s : s;
        r   = longint'((mag + 64'd32768) >> 16);
        return s < 0 ? -r : r;
    endfunction

    // Value and two derivatives of one cubic basis function.
    function automatic basis_res_t eval_basis(logic signed [31:0] pt, logic [1:0] idx);
        longint     x;
        int         l;
        int         i;
        longint     b [4];
        longint     pd [2];
        longint     da;
        longint     db;
        longint     fl;
        longint     fr;
        longint     gl;
        longint     gr;
        bit         flag;
        basis_res_t res;
        x    = longint'(pt);
        l    = int'(idx);
        flag = 1'b0;
        b    = '{0, 0, 0, 0};
        pd   = '{0, 0};
        b[(3 - l) & 3] = 65536;
        // First full level, degree one.
        for (int rr = 0; rr < 3; rr++)
        begin
            i  = l + rr;
            da = knot_val(i + 1) - knot_val(i);
            db = knot_val(i + 2) - knot_val(i + 1);
            fl = knot_ratio(x - knot_val(i), da, flag);
            fr = knot_ratio(knot_val(i + 2) - x, db, flag);
            b[rr] = clip_symmetric(mul_add_round(fl, b[rr], fr, b[rr + 1]), flag);
        end
        // Degree two: values and first derivatives.
        for (int rr = 0; rr < 2; rr++)
        begin
            i  = l + rr;
            da = knot_val(i + 2) - knot_val(i);
            db = knot_val(i + 3) - knot_val(i + 1);
            gl = knot_ratio(2 * 65536, da, flag);
            gr = knot_ratio(2 * 65536, db, flag);
            fl = knot_ratio(x - knot_val(i), da, flag);
            fr = knot_ratio(knot_val(i + 3) - x, db, flag);
            pd[rr] = clip_symmetric(mul_add_round(gl, b[rr], -gr, b[rr + 1]), flag);
            b[rr]  = clip_symmetric(mul_add_round(fl, b[rr], fr, b[rr + 1]), flag);
        end
        // Top level.
        da = knot_val(l + 3) - knot_val(l);
        db = knot_val(l + 4) - knot_val(l + 1);
        fl = knot_ratio(x - knot_val(l), da, flag);
        fr = knot_ratio(knot_val(l + 4) - x, db, flag);
        gl = knot_ratio(3 * 65536, da, flag);
        gr = knot_ratio(3 * 65536, db, flag);
        res.value  = 32'(clip_result(mul_add_round(fl, b[0], fr, b[1]), flag));
        res.deriv1 = 32'(clip_result(mul_add_round(gl, b[0], -gr, b[1]), flag));
        res.deriv2 = 32'(clip_result(mul_add_round(gl, pd[0], -gr, pd[1]), flag));
        res.sat    = flag;
        return res;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 60);
    endfunction

    task automatic send_point(logic signed [31:0] pt, logic [1:0] idx);
        in_valid    = 1'b1;
        point       = pt;
        basis_index = idx;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_results.push_back(eval_basis(pt, idx));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_knot(int k, logic [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = 3'(k);
        cfg_data  = data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        knot_copy[k] = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every transaction has come out, then let the pipeline empty.
    task automatic drain_pipeline();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_points(int count);
        logic signed [31:0] pt;
        int                 r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                pt = knot_copy[$urandom_range(0, NKNOT - 1)]
                     + $signed(32'($urandom_range(0, 131072))) - 32'sd65536;
            end
            else if (r < 75)
            begin
                pt = knot_copy[$urandom_range(0, NKNOT - 1)];
            end
            else
            begin
                pt = $urandom;
            end
            send_point(pt, 2'($urandom_range(0, 3)));
            repeat (pick_gap()) @(negedge clk);
        end
    endtask

    // Points on the knots, between them, outside the span and at the extremes.
    basis_req_t directed_points [20] = '{
        '{32'sd0,        2'd0}, '{32'sd65536,   2'd1}, '{32'sd196608,  2'd0},
        '{32'sd196608,   2'd1}, '{32'sd196608,  2'd2}, '{32'sd196608,  2'd3},
        '{32'sd229376,   2'd0}, '{32'sd229376,  2'd1}, '{32'sd229376,  2'd2},
        '{32'sd229376,   2'd3}, '{32'sd262144,  2'd0}, '{32'sd262144,  2'd3},
        '{32'sd458752,   2'd3}, '{-32'sd65536,  2'd0}, '{32'sd1048576, 2'd3},
        '{Q_MAX,         2'd0}, '{Q_MAX,        2'd3}, '{Q_MIN,        2'd0},
        '{Q_MIN,         2'd3}, '{32'sd32767,   2'd2}
    };

    // Stimulus.
    initial
    begin
        logic signed [31:0] acc;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        point       = '0;
        basis_index = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        stim_done   = 1'b0;
        for (int k = 0; k < NKNOT; k++)
        begin
            knot_copy[k] = 32'(k * 65536);
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed and random points over the reset knots.
        foreach (directed_points[n])
        begin
            send_point(directed_points[n].pt, directed_points[n].idx);
        end
        random_points(RANDOM_ITEMS);
        drain_pipeline();

        // All knots equal: every factor is zero.
        for (int k = 0; k < NKNOT; k++)
        begin
            write_knot(k, Q_MIN);
        end
        foreach (directed_points[n])
        begin
            send_point(directed_points[n].pt, directed_points[n].idx);
        end
        drain_pipeline();

        // Alternating extremes, to drive the stages into clipping.
        for (int k = 0; k < NKNOT; k++)
        begin
            write_knot(k, (k % 2) ? Q_MAX : Q_MIN);
        end
        random_points(RANDOM_ITEMS / 2);
        drain_pipeline();

        // Ascending knots with random spacing and some repeated knots.
        for (int pass = 0; pass < 3; pass++)
        begin
            acc = $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
            for (int k = 0; k < NKNOT; k++)
            begin
                write_knot(k, acc);
                if ($urandom_range(0, 4) != 0)
                begin
                    acc = acc + $signed(32'($urandom_range(1, 200000)));
                end
            end
            random_points(RANDOM_ITEMS);
            drain_pipeline();
        end

        // Arbitrary knots, all bits random.
        for (int k = 0; k < NKNOT; k++)
        begin
            write_knot(k, $urandom);
        end
        random_points(RANDOM_ITEMS / 2);
        drain_pipeline();

        // Back to the uniform knot vector.
        for (int k = 0; k < NKNOT; k++)
        begin
            write_knot(k, 32'(k * 65536));
        end
        random_points(RANDOM_ITEMS / 2);
        drain_pipeline();

        stim_done = 1'b1;
    end

    // Receiver back-pressure, in stretches with and without stalls.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                out_stall = 1'b0;
                repeat ($urandom_range(50, 200)) @(negedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 4)) @(negedge clk);
                gap = pick_gap();
                if (gap != 0)
                begin
                    out_stall = 1'b1;
                    repeat (gap) @(negedge clk);
                    out_stall = 1'b0;
                end
            end
        end
    end

    // Check each output transaction against the oldest expectation.
    always @(posedge clk)
    begin
        basis_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("Unexpected result: %h %h %h %b", basis_value,
                             first_derivative, second_derivative, saturated);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.value !== basis_value || want.deriv1 !== first_derivative ||
                    want.deriv2 !== second_derivative || want.sat !== saturated)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("Mismatch: expected %h %h %h %b, got %h %h %h %b",
                                 want.value, want.deriv1, want.deriv2, want.sat,
                                 basis_value, first_derivative, second_derivative,
                                 saturated);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction, and the end of the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (stim_done)
        begin
            if (mismatches == 0 && pending_results.size() == 0)
            begin
                $display("Testbench completed without errors");
            end
            else
            begin
                $display("Testbench completed WITH ERRORS");
            end
            $finish;
        end
        else if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
